>>> hw/rtl/svbs_pkg.sv
// ----------------------------------------------------------------------------
// svbs_pkg
// Shared types, codes and constants of the service VIP backend select unit.
// ----------------------------------------------------------------------------
package svbs_pkg;

    // Default table geometry
    localparam int SERVICE_ENTRIES_DEF      = 64;
    localparam int SLOTS_PER_SERVICE_DEF    = 256;
    localparam int BACKENDS_PER_SERVICE_DEF = 64;

    // Item kinds
    localparam logic [1:0] FN_LOOKUP    = 2'd0;
    localparam logic [1:0] FN_WR_SVC    = 2'd1;
    localparam logic [1:0] FN_WR_SLOT   = 2'd2;
    localparam logic [1:0] FN_WR_BACKEND = 2'd3;

    // Result status codes
    localparam logic [2:0] STAT_REDIRECT  = 3'd0;
    localparam logic [2:0] STAT_BYPASS    = 3'd1;
    localparam logic [2:0] STAT_PROTO     = 3'd2;
    localparam logic [2:0] STAT_NO_SVC    = 3'd3;
    localparam logic [2:0] STAT_DISABLED  = 3'd4;
    localparam logic [2:0] STAT_NO_SLOT   = 3'd5;
    localparam logic [2:0] STAT_BACKEND   = 3'd6;
    localparam logic [2:0] STAT_WR_DONE   = 3'd7;

    // Protocols, mode and flag bits
    localparam logic [7:0] PROTO_TCP      = 8'd6;
    localparam logic [7:0] PROTO_UDP      = 8'd17;
    localparam logic [7:0] MODE_NAT       = 8'd1;
    localparam int         FLAG_READY_BIT = 0;
    localparam int         FLAG_UNHEALTHY_BIT = 2;

    // Hash finalizer multipliers
    localparam logic [31:0] MIX_C1 = 32'h7feb352d;
    localparam logic [31:0] MIX_C2 = 32'h846ca68b;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] dest_addr;
        logic [15:0] dest_port;
        logic [7:0]  protocol;
        logic [5:0]  service_index;
        logic [8:0]  slot_count;
        logic [7:0]  service_mode;
        logic [7:0]  slot_index;
        logic [5:0]  backend_index;
        logic [31:0] backend_addr;
        logic [15:0] backend_port;
        logic [15:0] backend_flags;
    } req_t;

    typedef struct packed {
        logic        redirected;
        logic [31:0] result_addr;
        logic [15:0] result_port;
        logic [2:0]  status;
    } rsp_t;

    // Service entry: key plus settings
    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
        logic [7:0]  proto;
        logic [8:0]  size;
        logic [7:0]  mode;
    } svc_entry_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] backend;
    } slot_entry_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
        logic [15:0] port;
        logic        ready;
        logic        unhealthy;
    } be_entry_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_CHECK,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_HASH_WAIT,
        S_MOD_WAIT,
        S_SLOT_RD,
        S_SLOT_CHK,
        S_BE_CHK,
        S_DONE
    } state_t;

    // Shift-xor step of the finalizer
    function automatic logic [31:0] xsh16(input logic [31:0] x);
        xsh16 = x ^ (x >> 16);
    endfunction

    function automatic logic [31:0] xsh15(input logic [31:0] x);
        xsh15 = x ^ (x >> 15);
    endfunction

endpackage

>>> hw/rtl/service_vip_backend_select_unit.sv
// ----------------------------------------------------------------------------
// service_vip_backend_select_unit
// Maps a connection destination to a backend through service, slot and
// backend tables held in synchronous memories; also takes table writes.
//
//   channel   direction  handshake              beat
//   req       in         req_valid/req_ready    one lookup or table write
//   rsp       out        rsp_valid/rsp_ready    one result per item
//   cfg       in         cfg_wr_en              bypass bit
//
// A lookup scans the service memory, a read and a compare state per
// entry, up to the first hit, then waits on the hash unit (run in
// parallel), the remainder unit, and two dependent memory reads. After
// reset a clearing pass over max(SERVICE_ENTRIES*SLOTS_PER_SERVICE,
// SERVICE_ENTRIES*BACKENDS_PER_SERVICE) addresses runs, then req_ready rises.
// One item is in work at a time; a finished result waits in the output
// register while the next item is accepted.
// ----------------------------------------------------------------------------
module service_vip_backend_select_unit #(
    parameter int SERVICE_ENTRIES      = svbs_pkg::SERVICE_ENTRIES_DEF,
    parameter int SLOTS_PER_SERVICE    = svbs_pkg::SLOTS_PER_SERVICE_DEF,
    parameter int BACKENDS_PER_SERVICE = svbs_pkg::BACKENDS_PER_SERVICE_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  svbs_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output svbs_pkg::rsp_t rsp,
    input  logic           cfg_wr_en,
    input  logic           cfg_wr_data
);
    import svbs_pkg::*;

    localparam int SW         = (SERVICE_ENTRIES > 1) ? $clog2(SERVICE_ENTRIES) : 1;
    localparam int SLOT_DEPTH = SERVICE_ENTRIES * SLOTS_PER_SERVICE;
    localparam int SLOT_AW    = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int BE_DEPTH   = SERVICE_ENTRIES * BACKENDS_PER_SERVICE;
    localparam int BE_AW      = (BE_DEPTH > 1) ? $clog2(BE_DEPTH) : 1;
    localparam int CLR_DEPTH  = (SLOT_DEPTH > BE_DEPTH) ? SLOT_DEPTH : BE_DEPTH;
    localparam int CLR_AW     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

    state_t state_reg;
    state_t state_next;

    req_t   req_reg;
    rsp_t   hold_reg;
    rsp_t   hold_next;
    rsp_t   rsp_reg;
    logic   rsp_valid_reg;
    logic   bypass_reg;

    logic [SW-1:0]         scan_reg;
    logic [CLR_AW-1:0]     clr_reg;
    logic [SERVICE_ENTRIES-1:0] key_vld_reg;

    svc_entry_t  key_mem [SERVICE_ENTRIES];
    slot_entry_t slot_mem [SLOT_DEPTH];
    be_entry_t   be_mem [BE_DEPTH];

    svc_entry_t  key_rd_reg;
    slot_entry_t slot_rd_reg;
    be_entry_t   be_rd_reg;

    logic        key_we;
    svc_entry_t  key_wd;
    logic        slot_we;
    logic [SLOT_AW-1:0] slot_wa;
    slot_entry_t slot_wd;
    logic        be_we;
    logic [BE_AW-1:0] be_wa;
    be_entry_t   be_wd;
    logic [SLOT_AW-1:0] slot_ra;
    logic [BE_AW-1:0]   be_ra;

    logic        hash_start;
    logic        hash_done;
    logic [31:0] hash;
    logic        mod_start;
    logic        mod_done;
    logic [8:0]  rem;

    logic        sidx_ok;
    logic        slidx_ok;
    logic        bidx_ok;
    logic        proto_ok;
    logic        key_hit;
    logic        scan_last;
    logic        svc_ok;
    logic        slot_ok;
    logic        be_ok;
    logic        clr_last;
    logic        rsp_free;
    logic [8:0]  size_sat;
    rsp_t        pass_rsp;

    // Shared units
    svbs_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .addr  (req_reg.dest_addr),
        .port  (req_reg.dest_port),
        .proto (req_reg.protocol),
        .done  (hash_done),
        .hash  (hash)
    );

    svbs_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (hash),
        .divisor  (key_rd_reg.size),
        .done     (mod_done),
        .rem      (rem)
    );

    // Decode held item and memory read data
    always_comb
    begin
        sidx_ok   = 32'(req_reg.service_index) < 32'(SERVICE_ENTRIES);
        slidx_ok  = 32'(req_reg.slot_index) < 32'(SLOTS_PER_SERVICE);
        bidx_ok   = 32'(req_reg.backend_index) < 32'(BACKENDS_PER_SERVICE);
        proto_ok  = (req_reg.protocol == PROTO_TCP) || (req_reg.protocol == PROTO_UDP);
        key_hit   = key_vld_reg[scan_reg] && (key_rd_reg.addr == req_reg.dest_addr)
                    && (key_rd_reg.port == req_reg.dest_port)
                    && (key_rd_reg.proto == req_reg.protocol);
        scan_last = scan_reg == SW'(SERVICE_ENTRIES - 1);
        svc_ok    = (key_rd_reg.size != 9'd0) && (key_rd_reg.mode == MODE_NAT);
        slot_ok   = slot_rd_reg.valid
                    && (32'(slot_rd_reg.backend) < 32'(BACKENDS_PER_SERVICE));
        be_ok     = be_rd_reg.valid && be_rd_reg.ready && !be_rd_reg.unhealthy;
        clr_last  = clr_reg == CLR_AW'(CLR_DEPTH - 1);
        rsp_free  = !rsp_valid_reg || rsp_ready;
        size_sat  = (32'(req_reg.slot_count) > 32'(SLOTS_PER_SERVICE))
                    ? 9'(SLOTS_PER_SERVICE) : req_reg.slot_count;
        slot_ra   = SLOT_AW'(scan_reg) * SLOT_AW'(SLOTS_PER_SERVICE) + SLOT_AW'(rem);
        be_ra     = BE_AW'(scan_reg) * BE_AW'(BACKENDS_PER_SERVICE)
                    + BE_AW'(slot_rd_reg.backend);
        pass_rsp.redirected  = 1'b0;
        pass_rsp.result_addr = req_reg.dest_addr;
        pass_rsp.result_port = req_reg.dest_port;
        pass_rsp.status      = STAT_BYPASS;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (req.func == FN_LOOKUP) ? S_CHECK : S_WRITE;
                end
            end
            S_WRITE:
            begin
                state_next = S_DONE;
            end
            S_CHECK:
            begin
                state_next = (bypass_reg || !proto_ok) ? S_DONE : S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (key_hit)
                begin
                    state_next = svc_ok ? S_HASH_WAIT : S_DONE;
                end
                else
                begin
                    state_next = scan_last ? S_DONE : S_SCAN_RD;
                end
            end
            S_HASH_WAIT:
            begin
                if (hash_done)
                begin
                    state_next = S_MOD_WAIT;
                end
            end
            S_MOD_WAIT:
            begin
                if (mod_done)
                begin
                    state_next = S_SLOT_RD;
                end
            end
            S_SLOT_RD:
            begin
                state_next = S_SLOT_CHK;
            end
            S_SLOT_CHK:
            begin
                state_next = slot_ok ? S_BE_CHK : S_DONE;
            end
            S_BE_CHK:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Strobes, memory writes and result per state
    always_comb
    begin
        hash_start = 1'b0;
        mod_start  = 1'b0;
        key_we     = 1'b0;
        slot_we    = 1'b0;
        be_we      = 1'b0;
        hold_next  = hold_reg;
        key_wd.addr  = req_reg.dest_addr;
        key_wd.port  = req_reg.dest_port;
        key_wd.proto = req_reg.protocol;
        key_wd.size  = size_sat;
        key_wd.mode  = req_reg.service_mode;
        slot_wa = SLOT_AW'(req_reg.service_index) * SLOT_AW'(SLOTS_PER_SERVICE)
                  + SLOT_AW'(req_reg.slot_index);
        slot_wd.valid   = 1'b1;
        slot_wd.backend = req_reg.backend_index;
        be_wa   = BE_AW'(req_reg.service_index) * BE_AW'(BACKENDS_PER_SERVICE)
                  + BE_AW'(req_reg.backend_index);
        be_wd.valid     = 1'b1;
        be_wd.addr      = req_reg.backend_addr;
        be_wd.port      = req_reg.backend_port;
        be_wd.ready     = req_reg.backend_flags[FLAG_READY_BIT];
        be_wd.unhealthy = req_reg.backend_flags[FLAG_UNHEALTHY_BIT];
        case (state_reg)
            S_CLEAR:
            begin
                slot_we = {1'b0, clr_reg} < (CLR_AW + 1)'(SLOT_DEPTH);
                slot_wa = clr_reg[SLOT_AW-1:0];
                slot_wd = '0;
                be_we   = {1'b0, clr_reg} < (CLR_AW + 1)'(BE_DEPTH);
                be_wa   = clr_reg[BE_AW-1:0];
                be_wd   = '0;
            end
            S_WRITE:
            begin
                key_we  = sidx_ok && (req_reg.func == FN_WR_SVC);
                slot_we = sidx_ok && slidx_ok && bidx_ok && (req_reg.func == FN_WR_SLOT);
                be_we   = sidx_ok && bidx_ok && (req_reg.func == FN_WR_BACKEND);
                hold_next.redirected  = 1'b0;
                hold_next.result_addr = '0;
                hold_next.result_port = '0;
                hold_next.status      = STAT_WR_DONE;
            end
            S_CHECK:
            begin
                hold_next        = pass_rsp;
                hold_next.status = bypass_reg ? STAT_BYPASS : STAT_PROTO;
                hash_start       = !bypass_reg && proto_ok;
            end
            S_SCAN_CMP:
            begin
                hold_next        = pass_rsp;
                hold_next.status = key_hit ? STAT_DISABLED : STAT_NO_SVC;
            end
            S_HASH_WAIT:
            begin
                mod_start = hash_done;
            end
            S_SLOT_CHK:
            begin
                hold_next        = pass_rsp;
                hold_next.status = STAT_NO_SLOT;
            end
            S_BE_CHK:
            begin
                hold_next = pass_rsp;
                if (be_ok)
                begin
                    hold_next.redirected  = 1'b1;
                    hold_next.result_addr = be_rd_reg.addr;
                    hold_next.result_port = be_rd_reg.port;
                    hold_next.status      = STAT_REDIRECT;
                end
                else
                begin
                    hold_next.status = STAT_BACKEND;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
            bypass_reg    <= 1'b0;
            clr_reg       <= '0;
            scan_reg      <= '0;
            key_vld_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                bypass_reg <= cfg_wr_data;
            end
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + CLR_AW'(1);
            end
            if (state_reg == S_CHECK)
            begin
                scan_reg <= '0;
            end
            else if ((state_reg == S_SCAN_CMP) && !key_hit && !scan_last)
            begin
                scan_reg <= scan_reg + SW'(1);
            end
            if (key_we)
            begin
                key_vld_reg[SW'(req_reg.service_index)] <= 1'b1;
            end
            if ((state_reg == S_DONE) && rsp_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        hold_reg <= hold_next;
        if ((state_reg == S_DONE) && rsp_free)
        begin
            rsp_reg <= hold_reg;
        end
    end

    // Service memory
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[SW'(req_reg.service_index)] <= key_wd;
        end
        key_rd_reg <= key_mem[scan_reg];
    end

    // Slot memory
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wa] <= slot_wd;
        end
        slot_rd_reg <= slot_mem[slot_ra];
    end

    // Backend memory
    always_ff @(posedge clk)
    begin
        if (be_we)
        begin
            be_mem[be_wa] <= be_wd;
        end
        be_rd_reg <= be_mem[be_ra];
    end

    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> hw/rtl/svbs_hash.sv
// ----------------------------------------------------------------------------
// svbs_hash
// Destination hash: three finalizer passes on one shared multiplier, one
// multiply per cycle. Done rises after the last pass; holds until next start.
// ----------------------------------------------------------------------------
module svbs_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] addr,
    input  logic [15:0] port,
    input  logic [7:0]  proto,
    output logic        done,
    output logic [31:0] hash
);
    import svbs_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [2:0]  phase_reg;
    logic [31:0] x_reg;
    logic [31:0] x_next;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] seed;

    // Select multiplier operands per phase
    always_comb
    begin
        acc_next = acc_reg;
        seed     = '0;
        mul_a    = xsh15(x_reg);
        mul_b    = MIX_C2;
        case (phase_reg)
            3'd0:
            begin
                mul_a = xsh16(addr);
                mul_b = MIX_C1;
            end
            3'd2:
            begin
                acc_next = addr ^ xsh16(x_reg);
                mul_a    = xsh16({16'd0, port});
                mul_b    = MIX_C1;
            end
            3'd4:
            begin
                seed  = acc_reg ^ xsh16(x_reg) ^ {proto, 24'd0};
                mul_a = xsh16(seed);
                mul_b = MIX_C1;
            end
            default:
            begin
            end
        endcase
        x_next = mul_a * mul_b;
    end

    // Advance phases
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            phase_reg <= '0;
        end
        else if (busy_reg)
        begin
            phase_reg <= phase_reg + 3'd1;
            if (phase_reg == 3'd5)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Hold datapath
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            x_reg   <= x_next;
            acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign hash = xsh16(x_reg);

endmodule

>>> hw/rtl/svbs_mod.sv
// ----------------------------------------------------------------------------
// svbs_mod
// Remainder of a 32-bit hash by a table size of up to 256: restoring
// division, one dividend bit per cycle, done after all 32 dividend bits.
// ----------------------------------------------------------------------------
module svbs_mod (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [8:0]  divisor,
    output logic        done,
    output logic [8:0]  rem
);
    import svbs_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] dvd_reg;
    logic [8:0]  div_reg;
    logic [8:0]  rem_reg;
    logic [8:0]  rem_next;
    logic [9:0]  shifted;

    // Shift in one bit, subtract when it fits
    always_comb
    begin
        shifted = {rem_reg, dvd_reg[31]};
        if (shifted >= {1'b0, div_reg})
        begin
            rem_next = 9'(shifted - {1'b0, div_reg});
        end
        else
        begin
            rem_next = 9'(shifted);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

>>> tb/tb_service_vip_backend_select_unit.sv
// ----------------------------------------------------------------------------
// tb_service_vip_backend_select_unit
// Drives lookups and table writes into the backend select unit with random
// idling on both channels. A behavioral copy of the tables predicts every
// result beat, and each result beat is compared as a whole, in order.
// ----------------------------------------------------------------------------
module tb_service_vip_backend_select_unit;
    import svbs_pkg::*;

    localparam int NSVC  = SERVICE_ENTRIES_DEF;
    localparam int NSLOT = SLOTS_PER_SERVICE_DEF;
    localparam int NBE   = BACKENDS_PER_SERVICE_DEF;
    localparam int NDIR  = 20;
    localparam int NRAND = 1580;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;
    logic cfg_wr_en;
    logic cfg_wr_data;

    // Predictor copy of the block state
    logic        bypass_q;
    logic        svc_valid [NSVC];
    svc_entry_t  svc_mem [NSVC];
    slot_entry_t slot_mem [NSVC*NSLOT];
    be_entry_t   be_mem [NSVC*NBE];

    rsp_t expected_rsp [$];
    int   errors;
    logic quiet;
    logic rsp_idle_en;

    // Directed rows: item, whether a typed result applies, and that result
    typedef struct {
        req_t item;
        bit   fixed;
        rsp_t result;
    } dir_row_t;
    dir_row_t dir_rows [NDIR];

    service_vip_backend_select_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #300000000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [31:0] fin_mix(input logic [31:0] x);
        logic [31:0] v;
        v = x ^ (x >> 16);
        v = v * 32'h7feb352d;
        v = v ^ (v >> 15);
        v = v * 32'h846ca68b;
        v = v ^ (v >> 16);
        return v;
    endfunction

    // Apply one item to the table copy and produce its result
    function automatic rsp_t select_backend(input req_t r);
        rsp_t        o;
        int          hit;
        logic [31:0] h;
        int          slot;
        slot_entry_t s;
        be_entry_t   b;
        o.redirected  = 1'b0;
        o.result_addr = r.dest_addr;
        o.result_port = r.dest_port;
        hit = -1;
        if (r.func != FN_LOOKUP)
        begin
            o.result_addr = '0;
            o.result_port = '0;
            o.status = STAT_WR_DONE;
            if (r.func == FN_WR_SVC)
            begin
                svc_valid[r.service_index] = 1'b1;
                svc_mem[r.service_index] = '{r.dest_addr, r.dest_port, r.protocol,
                    (r.slot_count > NSLOT) ? 9'(NSLOT) : r.slot_count, r.service_mode};
            end
            else if (r.func == FN_WR_SLOT)
                slot_mem[r.service_index*NSLOT + r.slot_index] = '{1'b1, r.backend_index};
            else
                be_mem[r.service_index*NBE + r.backend_index] = '{1'b1, r.backend_addr,
                    r.backend_port, r.backend_flags[FLAG_READY_BIT],
                    r.backend_flags[FLAG_UNHEALTHY_BIT]};
        end
        else if (bypass_q)
            o.status = STAT_BYPASS;
        else if (r.protocol != PROTO_TCP && r.protocol != PROTO_UDP)
            o.status = STAT_PROTO;
        else
        begin
            for (int i = NSVC - 1; i >= 0; i--)
                if (svc_valid[i] && svc_mem[i].addr == r.dest_addr &&
                    svc_mem[i].port == r.dest_port && svc_mem[i].proto == r.protocol)
                    hit = i;
            if (hit < 0)
                o.status = STAT_NO_SVC;
            else if (svc_mem[hit].size == 0 || svc_mem[hit].mode != MODE_NAT)
                o.status = STAT_DISABLED;
            else
            begin
                h = fin_mix(r.dest_addr ^ fin_mix(r.dest_addr) ^ fin_mix({16'd0, r.dest_port})
                    ^ {r.protocol, 24'd0});
                slot = h % svc_mem[hit].size;
                s = slot_mem[hit*NSLOT + slot];
                if (!s.valid)
                    o.status = STAT_NO_SLOT;
                else
                begin
                    b = be_mem[hit*NBE + s.backend];
                    if (!b.valid || !b.ready || b.unhealthy)
                        o.status = STAT_BACKEND;
                    else
                    begin
                        o.redirected  = 1'b1;
                        o.result_addr = b.addr;
                        o.result_port = b.port;
                        o.status = STAT_REDIRECT;
                    end
                end
            end
        end
        return o;
    endfunction

    // Random item; mostly keys from a small pool so lookups reach deep
    function automatic req_t rand_item();
        req_t r;
        int   k;
        r = ($bits(req_t))'({$urandom, $urandom, $urandom, $urandom, $urandom});
        k = $urandom_range(0, 7);
        r.func = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 9) < 8)
        begin
            r.dest_addr = 32'h0a000000 + 32'(k);
            r.dest_port = 16'(16'd80 + 16'(k));
            r.protocol = k[0] ? PROTO_UDP : PROTO_TCP;
            r.service_index = 6'($urandom_range(0, 9));
            r.slot_count = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                                       : 9'($urandom_range(1, 4));
            r.service_mode = ($urandom_range(0, 4) == 0) ? 8'($urandom) : MODE_NAT;
            r.slot_index = 8'($urandom_range(0, 3));
            r.backend_index = 6'($urandom_range(0, 3));
            r.backend_flags = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'h0001;
        end
        return r;
    endfunction

    function automatic req_t mk(input logic [1:0] f, input logic [31:0] a,
                                input logic [15:0] p, input logic [7:0] pr);
        req_t r;
        r = '0;
        r.func = f;
        r.dest_addr = a;
        r.dest_port = p;
        r.protocol = pr;
        return r;
    endfunction

    task automatic build_rows();
        req_t r;
        rsp_t wr;
        wr = '{1'b0, 32'd0, 16'd0, STAT_WR_DONE};
        // lookup before any write: no service
        r = mk(FN_LOOKUP, 32'hffffffff, 16'hffff, PROTO_TCP);
        dir_rows[0] = '{r, 1'b1, '{1'b0, 32'hffffffff, 16'hffff, STAT_NO_SVC}};
        r = mk(FN_LOOKUP, 32'h0, 16'h0, 8'hff);
        dir_rows[1] = '{r, 1'b1, '{1'b0, 32'h0, 16'h0, STAT_PROTO}};
        // service 63 at extremes, slot count saturates
        r = mk(FN_WR_SVC, 32'hffffffff, 16'hffff, PROTO_UDP);
        r.service_index = 6'd63; r.slot_count = 9'h1ff; r.service_mode = MODE_NAT;
        dir_rows[2] = '{r, 1'b1, wr};
        for (int i = 0; i < 4; i++)
        begin
            r = '1;
            r.func = FN_WR_BACKEND; r.service_index = 6'd63;
            r.backend_index = 6'(63 - i);
            r.backend_flags = (i == 1) ? 16'hfffe : (i == 2) ? 16'h0005 : 16'h0001;
            r.backend_addr = 32'hc0a80000 + 32'(i);
            dir_rows[3+i] = '{r, 1'b1, wr};
        end
        for (int i = 0; i < 6; i++)
        begin
            r = '1;
            r.func = FN_WR_SLOT; r.service_index = 6'd63;
            dir_rows[7+i] = '{r, 1'b0, wr};
        end
        for (int i = 0; i < 6; i++)
        begin
            dir_rows[7+i].item.slot_index = 8'(i * 51);
            dir_rows[7+i].item.backend_index = 6'(63 - (i % 4));
        end
        r = mk(FN_LOOKUP, 32'hffffffff, 16'hffff, PROTO_UDP);
        dir_rows[13] = '{r, 1'b0, wr};
        // disabled services: zero size, non-NAT mode; lowest index wins
        r = mk(FN_WR_SVC, 32'h0, 16'h0, PROTO_TCP);
        r.service_index = 6'd0; r.slot_count = 9'd0; r.service_mode = MODE_NAT;
        dir_rows[14] = '{r, 1'b1, wr};
        r = mk(FN_LOOKUP, 32'h0, 16'h0, PROTO_TCP);
        dir_rows[15] = '{r, 1'b1, '{1'b0, 32'h0, 16'h0, STAT_DISABLED}};
        r = mk(FN_WR_SVC, 32'hffffffff, 16'hffff, PROTO_UDP);
        r.service_index = 6'd5; r.slot_count = 9'd1; r.service_mode = 8'hff;
        dir_rows[16] = '{r, 1'b1, wr};
        r = mk(FN_LOOKUP, 32'hffffffff, 16'hffff, PROTO_UDP);
        dir_rows[17] = '{r, 1'b1, '{1'b0, 32'hffffffff, 16'hffff, STAT_DISABLED}};
        r = mk(FN_WR_SVC, 32'hffffffff, 16'hffff, PROTO_UDP);
        r.service_index = 6'd5; r.slot_count = 9'd1; r.service_mode = MODE_NAT;
        dir_rows[18] = '{r, 1'b1, wr};
        r = mk(FN_LOOKUP, 32'hffffffff, 16'hffff, PROTO_UDP);
        dir_rows[19] = '{r, 1'b1, '{1'b0, 32'hffffffff, 16'hffff, STAT_NO_SLOT}};
    endtask

    // Send one item: hold valid and payload until the beat is taken;
    // drop valid only when an idle burst follows
    task automatic send_item(input req_t r, input bit fixed, input rsp_t fixed_rsp);
        rsp_t p;
        int   gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do @(posedge clk); while (!req_ready);
        p = select_backend(r);
        if (fixed && p !== fixed_rsp)
        begin
            $display("%0t predictor row mismatch exp=%h act=%h", $time, fixed_rsp, p);
            errors++;
        end
        expected_rsp.push_back(fixed ? fixed_rsp : p);
    endtask

    // Write bypass while idle
    task automatic set_bypass(input logic v);
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        bypass_q = v;
    endtask

    // Result side: random stall bursts, compare each beat
    initial
    begin
        int stall;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rsp_idle_en && !quiet && $urandom_range(0, 3) == 0)
            begin
                stall = $urandom_range(1, 9);
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $display("%0t unexpected result act=%h", $time, rsp);
                    errors++;
                end
                else if (rsp !== expected_rsp[0])
                begin
                    $display("%0t mismatch exp=%h act=%h", $time, expected_rsp[0], rsp);
                    errors++;
                    void'(expected_rsp.pop_front());
                end
                else
                    void'(expected_rsp.pop_front());
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        errors = 0;
        quiet = 1'b0;
        rsp_idle_en = 1'b1;
        bypass_q = 1'b0;
        for (int i = 0; i < NSVC; i++)
        begin
            svc_valid[i] = 1'b0;
            svc_mem[i] = '0;
        end
        foreach (slot_mem[i]) slot_mem[i] = '0;
        foreach (be_mem[i]) be_mem[i] = '0;
        build_rows();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table
        set_bypass(1'b0);
        for (int i = 0; i < NDIR; i++)
            send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].result);

        // Bypass extreme
        set_bypass(1'b1);
        send_item(mk(FN_LOOKUP, 32'h12345678, 16'h9abc, PROTO_TCP), 1'b1,
                  '{1'b0, 32'h12345678, 16'h9abc, STAT_BYPASS});
        for (int i = 0; i < 100; i++)
            send_item(rand_item(), 1'b0, '0);
        set_bypass(1'b0);

        // Random part, bursts of idling, then a quiet tail
        for (int i = 0; i < NRAND; i++)
        begin
            if (i == NRAND - 150)
                quiet = 1'b1;
            send_item(rand_item(), 1'b0, '0);
        end
        req_valid <= 1'b0;

        while (expected_rsp.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_rsp.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
